// File: sv/stationary_gated_zero_averager_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stationary gated zero averager unit
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef STATIONARY_GATED_ZERO_AVERAGER_UNIT_MACROS_SVH
`define STATIONARY_GATED_ZERO_AVERAGER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGZA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define SGZA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: sv/sgza_pkg.sv
// ----------------------------------------------------------------------------
// sgza_pkg
// Widths, register indexes, capture status codes and shared types of the
// stationary gated zero averager unit.
// ----------------------------------------------------------------------------
package sgza_pkg;

  localparam int ANGLE_W   = 16;
  localparam int RAW_W     = 16;
  localparam int WINDOW_W  = 15;
  localparam int DWELL_W   = 16;
  localparam int CFG_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int TALLY_W   = 7;
  localparam int SUM_W     = 22;
  localparam int N_CH      = 4;
  localparam int DELTA_W   = ANGLE_W + 2;

  localparam int COUNTS_PER_REV  = 65536;
  localparam int AVERAGE_SAMPLES = 64;

  // Configuration register indexes.
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_DWELL  = 1'b1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(16);
  localparam logic [DWELL_W-1:0]  DWELL_RESET  = DWELL_W'(10000);

  typedef logic [STATUS_W-1:0] cap_status_t;

  localparam cap_status_t CAP_NONE       = 3'd0;
  localparam cap_status_t CAP_STARTED    = 3'd1;
  localparam cap_status_t CAP_DONE       = 3'd2;
  localparam cap_status_t CAP_ABORTED    = 3'd3;
  localparam cap_status_t CAP_REJ_BUSY   = 3'd4;
  localparam cap_status_t CAP_REJ_MOVING = 3'd5;

  typedef logic [RAW_W-1:0] raw_t;

  // Standstill flag as held before this item and as it will be after it.
  typedef struct packed {
    logic flag;
    logic flag_nxt;
  } standstill_t;

endpackage

// File: sv/sgza_standstill.sv
// ----------------------------------------------------------------------------
// sgza_standstill
// Anchor angle, saturating dwell counter and the stationary flag.
// ----------------------------------------------------------------------------
module sgza_standstill (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          sample_fire,
  input  logic [sgza_pkg::ANGLE_W-1:0]  angle,
  input  logic                          invalid,
  input  logic [sgza_pkg::WINDOW_W-1:0] window_counts,
  input  logic [sgza_pkg::DWELL_W-1:0]  dwell_samples,
  output sgza_pkg::standstill_t         still
);

  localparam logic signed [sgza_pkg::DELTA_W-1:0] REV =
    sgza_pkg::DELTA_W'(sgza_pkg::COUNTS_PER_REV);
  localparam logic signed [sgza_pkg::DELTA_W-1:0] HALF_REV =
    sgza_pkg::DELTA_W'(sgza_pkg::COUNTS_PER_REV / 2);

  logic                         tracking_r, tracking_nxt;
  logic [sgza_pkg::ANGLE_W-1:0] anchor_r, anchor_nxt;
  logic [sgza_pkg::DWELL_W-1:0] dwell_r, dwell_nxt;
  logic                         flag_r, flag_nxt;

  logic signed [sgza_pkg::DELTA_W-1:0] delta_raw;
  logic signed [sgza_pkg::DELTA_W-1:0] delta;
  logic signed [sgza_pkg::DELTA_W-1:0] win;
  logic                                outside;

  always_comb begin
    delta_raw = $signed({2'b00, angle}) - $signed({2'b00, anchor_r});
    if (delta_raw > HALF_REV) begin
      delta = delta_raw - REV;
    end else if (delta_raw < -HALF_REV) begin
      delta = delta_raw + REV;
    end else begin
      delta = delta_raw;
    end
    win     = $signed({3'b000, window_counts});
    outside = (delta > win) || (delta < -win);
  end

  always_comb begin
    tracking_nxt = tracking_r;
    anchor_nxt   = anchor_r;
    dwell_nxt    = dwell_r;
    flag_nxt     = flag_r;
    if (invalid) begin
      tracking_nxt = 1'b0;
      dwell_nxt    = '0;
      flag_nxt     = 1'b0;
    end else if (!tracking_r || outside) begin
      // First valid sample or a jump out of the window: re-anchor here.
      tracking_nxt = 1'b1;
      anchor_nxt   = angle;
      dwell_nxt    = sgza_pkg::DWELL_W'(1);
      flag_nxt     = 1'b0;
    end else begin
      if (dwell_r < dwell_samples) begin
        dwell_nxt = dwell_r + sgza_pkg::DWELL_W'(1);
      end
      flag_nxt = (dwell_nxt >= dwell_samples);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r <= 1'b0;
      anchor_r   <= '0;
      dwell_r    <= '0;
      flag_r     <= 1'b0;
    end else if (sample_fire) begin
      tracking_r <= tracking_nxt;
      anchor_r   <= anchor_nxt;
      dwell_r    <= dwell_nxt;
      flag_r     <= flag_nxt;
    end
  end

  assign still.flag     = flag_r;
  assign still.flag_nxt = flag_nxt;

endmodule

// File: sv/sgza_capture.sv
// ----------------------------------------------------------------------------
// sgza_capture
// Zero capture control, the four channel sums and the rounded averages.
// ----------------------------------------------------------------------------
module sgza_capture (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic                  kind,
  input  sgza_pkg::raw_t        ch [sgza_pkg::N_CH],
  input  sgza_pkg::standstill_t still,
  output sgza_pkg::cap_status_t status,
  output sgza_pkg::raw_t        avg [sgza_pkg::N_CH]
);

  localparam int RND_W = sgza_pkg::SUM_W + 1;

  logic                         active_r, active_nxt;
  logic [sgza_pkg::TALLY_W-1:0] tally_r, tally_nxt;
  logic [sgza_pkg::SUM_W-1:0]   sums_r   [sgza_pkg::N_CH];
  logic [sgza_pkg::SUM_W-1:0]   sums_nxt [sgza_pkg::N_CH];
  logic [sgza_pkg::SUM_W-1:0]   sum_add  [sgza_pkg::N_CH];
  logic [RND_W-1:0]             rounded  [sgza_pkg::N_CH];
  logic [sgza_pkg::TALLY_W-1:0] tally_inc;

  always_comb begin
    tally_inc = tally_r + sgza_pkg::TALLY_W'(1);
    for (int i = 0; i < sgza_pkg::N_CH; i++) begin
      sum_add[i] = sums_r[i] + sgza_pkg::SUM_W'(ch[i]);
      rounded[i] = RND_W'(sum_add[i]) + RND_W'(sgza_pkg::AVERAGE_SAMPLES / 2);
    end
  end

  always_comb begin
    active_nxt = active_r;
    tally_nxt  = tally_r;
    sums_nxt   = sums_r;
    status     = sgza_pkg::CAP_NONE;
    for (int i = 0; i < sgza_pkg::N_CH; i++) begin
      avg[i] = '0;
    end
    if (kind) begin
      if (active_r) begin
        status = sgza_pkg::CAP_REJ_BUSY;
      end else if (!still.flag) begin
        status = sgza_pkg::CAP_REJ_MOVING;
      end else begin
        for (int i = 0; i < sgza_pkg::N_CH; i++) begin
          sums_nxt[i] = '0;
        end
        tally_nxt  = '0;
        active_nxt = 1'b1;
        status     = sgza_pkg::CAP_STARTED;
      end
    end else if (active_r) begin
      if (!still.flag_nxt) begin
        active_nxt = 1'b0;
        status     = sgza_pkg::CAP_ABORTED;
      end else begin
        sums_nxt  = sum_add;
        tally_nxt = tally_inc;
        if (tally_inc >= sgza_pkg::TALLY_W'(sgza_pkg::AVERAGE_SAMPLES)) begin
          for (int i = 0; i < sgza_pkg::N_CH; i++) begin
            avg[i] = sgza_pkg::RAW_W'(rounded[i] / sgza_pkg::AVERAGE_SAMPLES);
          end
          active_nxt = 1'b0;
          status     = sgza_pkg::CAP_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tally_r  <= '0;
      for (int i = 0; i < sgza_pkg::N_CH; i++) begin
        sums_r[i] <= '0;
      end
    end else if (fire) begin
      active_r <= active_nxt;
      tally_r  <= tally_nxt;
      sums_r   <= sums_nxt;
    end
  end

endmodule

// File: sv/stationary_gated_zero_averager_unit.sv
// ----------------------------------------------------------------------------
// stationary_gated_zero_averager_unit
// Standstill detector with gated zero-offset averaging of four raw channels.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel (in_valid/in_stall) is either a
// sample (in_kind 0) or a request to start a zero capture (in_kind 1). Every
// input transfer produces exactly one transfer on the result channel
// (out_valid/out_stall) carrying the stationary flag after that item, the
// capture status, and the four rounded channel means when the status is done.
// The two configuration registers (window and dwell) are written through
// cfg_wr_en/cfg_index/cfg_wdata, one register per cycle, while the block is
// idle. An accepted item is held in the input register, the standstill and
// capture logic then evaluate in one pass and the result lands in the output
// register. Throughput is one item per clock unless the receiver stalls;
// the rate is set by the single combinational pass from input register to
// result register, which also updates the tracking and capture state.
// A synchronous reset (rst_n low) empties both registers, clears tracking,
// the dwell count, the flag and any running capture, and restores the
// register defaults. When the receiver stalls, the result is held, the input
// register can still fill once, and only then is in_stall raised.
// ----------------------------------------------------------------------------
`include "stationary_gated_zero_averager_unit_macros.svh"

module stationary_gated_zero_averager_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [sgza_pkg::CFG_W-1:0]    cfg_wdata,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [sgza_pkg::ANGLE_W-1:0]  in_angle_count,
  input  logic                          in_position_invalid,
  input  logic [sgza_pkg::RAW_W-1:0]    in_a1_sin_raw,
  input  logic [sgza_pkg::RAW_W-1:0]    in_a1_cos_raw,
  input  logic [sgza_pkg::RAW_W-1:0]    in_a2_sin_raw,
  input  logic [sgza_pkg::RAW_W-1:0]    in_a2_cos_raw,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_stationary,
  output logic [sgza_pkg::STATUS_W-1:0] out_capture_status,
  output logic [sgza_pkg::RAW_W-1:0]    out_avg_a1_sin,
  output logic [sgza_pkg::RAW_W-1:0]    out_avg_a1_cos,
  output logic [sgza_pkg::RAW_W-1:0]    out_avg_a2_sin,
  output logic [sgza_pkg::RAW_W-1:0]    out_avg_a2_cos
);

  // Configuration registers.
  logic [sgza_pkg::WINDOW_W-1:0] window_r;
  logic [sgza_pkg::DWELL_W-1:0]  dwell_r;

  // Input register stage.
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_kind_r;
  logic [sgza_pkg::ANGLE_W-1:0] s1_angle_r;
  logic                         s1_invalid_r;
  sgza_pkg::raw_t               s1_ch_r [sgza_pkg::N_CH];

  // Result register stage.
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_stationary_r;
  sgza_pkg::cap_status_t out_status_r;
  sgza_pkg::raw_t        out_avg_r [sgza_pkg::N_CH];

  logic                  in_fire;
  logic                  s1_adv;
  logic                  out_fire;
  sgza_pkg::standstill_t still;
  sgza_pkg::cap_status_t cap_status;
  sgza_pkg::raw_t        cap_avg [sgza_pkg::N_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= sgza_pkg::WINDOW_RESET;
      dwell_r  <= sgza_pkg::DWELL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sgza_pkg::REG_WINDOW: window_r <= cfg_wdata[sgza_pkg::WINDOW_W-1:0];
        sgza_pkg::REG_DWELL:  dwell_r  <= cfg_wdata[sgza_pkg::DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the result register is empty or
  // its content is being taken this cycle; it refills in the same cycle.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r    <= in_kind;
      s1_angle_r   <= in_angle_count;
      s1_invalid_r <= in_position_invalid;
      s1_ch_r[0]   <= in_a1_sin_raw;
      s1_ch_r[1]   <= in_a1_cos_raw;
      s1_ch_r[2]   <= in_a2_sin_raw;
      s1_ch_r[3]   <= in_a2_cos_raw;
    end
  end

  // Start requests leave standstill tracking untouched.
  sgza_standstill u_standstill (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_fire   (s1_adv && !s1_kind_r),
    .angle         (s1_angle_r),
    .invalid       (s1_invalid_r),
    .window_counts (window_r),
    .dwell_samples (dwell_r),
    .still         (still)
  );

  sgza_capture u_capture (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_adv),
    .kind   (s1_kind_r),
    .ch     (s1_ch_r),
    .still  (still),
    .status (cap_status),
    .avg    (cap_avg)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_stationary_r <= s1_kind_r ? still.flag : still.flag_nxt;
      out_status_r     <= cap_status;
      out_avg_r        <= cap_avg;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_stationary     = out_stationary_r;
  assign out_capture_status = out_status_r;
  assign out_avg_a1_sin     = out_avg_r[0];
  assign out_avg_a1_cos     = out_avg_r[1];
  assign out_avg_a2_sin     = out_avg_r[2];
  assign out_avg_a2_cos     = out_avg_r[3];

  // Back-pressure only arises with both stages full.
  `SGZA_ASSERT_SAME(a_stall_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  // An advancing input stage always leaves a result behind.
  `SGZA_ASSERT_NEXT(a_adv_fills, clk, rst_n, s1_adv, out_valid_r)
  // A finished capture can only come from a stationary shaft.
  `SGZA_ASSERT_SAME(a_done_still, clk, rst_n,
    out_valid_r && (out_status_r == sgza_pkg::CAP_DONE), out_stationary_r)
  // Abort and motion rejection both report a moving shaft.
  `SGZA_ASSERT_SAME(a_moving_flag, clk, rst_n,
    out_valid_r && ((out_status_r == sgza_pkg::CAP_ABORTED) ||
    (out_status_r == sgza_pkg::CAP_REJ_MOVING)), !out_stationary_r)

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the stationary gated zero averager unit
// A short table of directed steps first covers the field extremes, the
// standstill window edges, and every capture status except done. Randomized
// capture sequences under several register settings and stall patterns follow.
// Every result transfer is checked against a behavioral predictor or a typed row.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sgza_pkg::*;

  // One input item as it travels on the input channel. Channel order is
  // a1 sin, a1 cos, a2 sin, a2 cos.
  typedef struct packed {
    logic                  kind;
    logic [ANGLE_W-1:0]    angle;
    logic                  invalid;
    raw_t [N_CH-1:0]       ch;
  } sample_item_t;

  // One result item as it travels on the result channel.
  typedef struct packed {
    logic                  stationary;
    cap_status_t           status;
    raw_t [N_CH-1:0]       avg;
  } capture_result_t;

  // A step of the directed plan: either a register setting or an item. Where
  // typed is set, the expected result is given in the row itself.
  typedef struct packed {
    logic                  is_setting;
    logic [CFG_W-1:0]      win_data;
    logic [CFG_W-1:0]      dwell_data;
    sample_item_t          item;
    logic                  typed;
    capture_result_t       typed_res;
  } plan_row_t;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 48;

  // Clock, reset and every input of the block start at known values.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_index = REG_WINDOW;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_kind = 1'b0;
  logic [ANGLE_W-1:0]    in_angle_count = '0;
  logic                  in_position_invalid = 1'b0;
  logic [RAW_W-1:0]      in_a1_sin_raw = '0;
  logic [RAW_W-1:0]      in_a1_cos_raw = '0;
  logic [RAW_W-1:0]      in_a2_sin_raw = '0;
  logic [RAW_W-1:0]      in_a2_cos_raw = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_stationary;
  logic [STATUS_W-1:0]   out_capture_status;
  logic [RAW_W-1:0]      out_avg_a1_sin;
  logic [RAW_W-1:0]      out_avg_a1_cos;
  logic [RAW_W-1:0]      out_avg_a2_sin;
  logic [RAW_W-1:0]      out_avg_a2_cos;

  always #5 clk = ~clk;

  stationary_gated_zero_averager_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_angle_count      (in_angle_count),
    .in_position_invalid (in_position_invalid),
    .in_a1_sin_raw       (in_a1_sin_raw),
    .in_a1_cos_raw       (in_a1_cos_raw),
    .in_a2_sin_raw       (in_a2_sin_raw),
    .in_a2_cos_raw       (in_a2_cos_raw),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_stationary      (out_stationary),
    .out_capture_status  (out_capture_status),
    .out_avg_a1_sin      (out_avg_a1_sin),
    .out_avg_a1_cos      (out_avg_a1_cos),
    .out_avg_a2_sin      (out_avg_a2_sin),
    .out_avg_a2_cos      (out_avg_a2_cos)
  );

  // Predictor state: a private copy of the registers, the standstill tracker
  // and the capture accumulator.
  logic [WINDOW_W-1:0]   win_reg = WINDOW_RESET;
  logic [DWELL_W-1:0]    dwell_reg = DWELL_RESET;
  logic                  trk = 1'b0;
  logic [ANGLE_W-1:0]    anchor = '0;
  logic [DWELL_W-1:0]    dwell_cnt = '0;
  logic                  still_flag = 1'b0;
  logic                  cap_on = 1'b0;
  logic [TALLY_W-1:0]    tally = '0;
  logic [SUM_W-1:0]      chan_sum [N_CH];

  // Results that have been predicted but not yet seen on the result channel.
  capture_result_t       due_results [$];

  int items_sent = 0;
  int results_seen = 0;
  int bad_results = 0;
  int send_idle = 22;
  int recv_idle = 66;
  int hold_left = 0;
  int raw_mode = 0;

  // Works out the result of one accepted item and advances the predictor
  // state exactly as the block does.
  function automatic capture_result_t expected_capture_result(sample_item_t it);
    capture_result_t r;
    int d;
    r = '0;
    r.status = CAP_NONE;
    if (it.kind) begin
      // A start request never touches the standstill tracker.
      if (cap_on) begin
        r.status = CAP_REJ_BUSY;
      end else if (!still_flag) begin
        r.status = CAP_REJ_MOVING;
      end else begin
        for (int i = 0; i < N_CH; i++) chan_sum[i] = '0;
        tally = '0;
        cap_on = 1'b1;
        r.status = CAP_STARTED;
      end
    end else begin
      if (it.invalid) begin
        trk = 1'b0;
        dwell_cnt = '0;
        still_flag = 1'b0;
      end else if (!trk) begin
        anchor = it.angle;
        dwell_cnt = 1;
        trk = 1'b1;
        still_flag = 1'b0;
      end else begin
        // The delta is wrapped once into half a revolution either way; a
        // delta of exactly half a revolution keeps its sign.
        d = int'(it.angle) - int'(anchor);
        if (d > COUNTS_PER_REV / 2) d -= COUNTS_PER_REV;
        else if (d < -(COUNTS_PER_REV / 2)) d += COUNTS_PER_REV;
        if (d > int'(win_reg) || d < -int'(win_reg)) begin
          anchor = it.angle;
          dwell_cnt = 1;
          still_flag = 1'b0;
        end else begin
          if (dwell_cnt < dwell_reg) dwell_cnt = dwell_cnt + 1'b1;
          still_flag = (dwell_cnt >= dwell_reg);
        end
      end
      if (cap_on) begin
        if (!still_flag) begin
          cap_on = 1'b0;
          r.status = CAP_ABORTED;
        end else begin
          for (int i = 0; i < N_CH; i++) chan_sum[i] = chan_sum[i] + SUM_W'(it.ch[i]);
          tally = tally + 1'b1;
          if (int'(tally) >= AVERAGE_SAMPLES) begin
            for (int i = 0; i < N_CH; i++) begin
              r.avg[i] = RAW_W'((int'(chan_sum[i]) + int'(tally) / 2) / int'(tally));
            end
            cap_on = 1'b0;
            r.status = CAP_DONE;
          end
        end
      end
    end
    r.stationary = still_flag;
    return r;
  endfunction

  function automatic plan_row_t setting_row(logic [CFG_W-1:0] w, logic [CFG_W-1:0] d);
    plan_row_t r;
    r = '0;
    r.is_setting = 1'b1;
    r.win_data = w;
    r.dwell_data = d;
    return r;
  endfunction

  function automatic plan_row_t item_row(logic kind, logic [ANGLE_W-1:0] ang, logic inv,
                                         raw_t raw, logic typed, logic st,
                                         cap_status_t cs);
    plan_row_t r;
    r = '0;
    r.item.kind = kind;
    r.item.angle = ang;
    r.item.invalid = inv;
    r.item.ch = {N_CH{raw}};
    r.typed = typed;
    r.typed_res.stationary = st;
    r.typed_res.status = cs;
    return r;
  endfunction

  // A sample item; the raw channels follow the current raw mode so that
  // some captures average all-ones or all-zeros data.
  function automatic sample_item_t sample_at(logic [ANGLE_W-1:0] ang, logic inv);
    sample_item_t it;
    it.kind = 1'b0;
    it.angle = ang;
    it.invalid = inv;
    for (int i = 0; i < N_CH; i++) begin
      it.ch[i] = (raw_mode == 1) ? '1 : (raw_mode == 2) ? '0 : RAW_W'($urandom);
    end
    return it;
  endfunction

  // A start request; its angle and channel fields are don't-care for the
  // block but get random values anyway.
  function automatic sample_item_t start_item();
    sample_item_t it;
    it.kind = 1'b1;
    it.angle = ANGLE_W'($urandom);
    it.invalid = 1'($urandom);
    for (int i = 0; i < N_CH; i++) it.ch[i] = RAW_W'($urandom);
    return it;
  endfunction

  // An angle within +-w counts of the base, wrapped into one revolution.
  function automatic logic [ANGLE_W-1:0] near(logic [ANGLE_W-1:0] base, int w);
    return base + ANGLE_W'(int'($urandom_range(0, 2 * w)) - w);
  endfunction

  // Offers one item on the input channel, after a random gap, and holds it
  // until the transfer happens. The prediction is made at the accepting edge.
  task automatic offer(sample_item_t it, logic typed, capture_result_t typed_res);
    capture_result_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_angle_count <= it.angle;
    in_position_invalid <= it.invalid;
    in_a1_sin_raw <= it.ch[0];
    in_a1_cos_raw <= it.ch[1];
    in_a2_sin_raw <= it.ch[2];
    in_a2_cos_raw <= it.ch[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = expected_capture_result(it);
    due_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // Lets the block run dry, then writes both registers on consecutive edges.
  task automatic apply_settings(logic [CFG_W-1:0] w, logic [CFG_W-1:0] d);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_WINDOW;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_DWELL;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_reg = w[WINDOW_W-1:0];
    dwell_reg = d[DWELL_W-1:0];
  endtask

  // A well-formed capture: settle at a random base angle long enough to
  // raise the stationary flag, request a capture, then feed it samples that
  // stay in the window. Now and then a second start request (rejected as
  // busy) or a motion sample (abort) is mixed in.
  task automatic capture_sequence();
    logic [ANGLE_W-1:0] base;
    int w;
    w = int'(win_reg);
    base = ANGLE_W'($urandom);
    raw_mode = ($urandom_range(0, 9) < 2) ? int'($urandom_range(1, 2)) : 0;
    if ($urandom_range(0, 3) != 0) offer(sample_at(ANGLE_W'($urandom), 1'b1), 1'b0, '0);
    offer(sample_at(base, 1'b0), 1'b0, '0);
    repeat (int'(dwell_reg)) offer(sample_at(near(base, w), 1'b0), 1'b0, '0);
    offer(start_item(), 1'b0, '0);
    repeat (AVERAGE_SAMPLES) begin
      if ($urandom_range(0, 39) == 0) offer(start_item(), 1'b0, '0);
      if ($urandom_range(0, 199) == 0) begin
        offer(sample_at(base + ANGLE_W'(COUNTS_PER_REV / 2), 1'($urandom)), 1'b0, '0);
      end
      offer(sample_at(near(base, w), 1'b0), 1'b0, '0);
    end
    raw_mode = 0;
  endtask

  // Result side: checks every transfer against the oldest prediction and
  // chooses the stall for the next cycle. Once per 97 results, when the
  // receiver is otherwise never stalling, it holds off for a long stretch
  // so that the block fills up and pushes back on its input.
  always @(posedge clk) begin : result_side
    capture_result_t got;
    capture_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.stationary = out_stationary;
      got.status = out_capture_status;
      got.avg[0] = out_avg_a1_sin;
      got.avg[1] = out_avg_a1_cos;
      got.avg[2] = out_avg_a2_sin;
      got.avg[3] = out_avg_a2_cos;
      if (due_results.size() == 0) begin
        if (bad_results < 10) $display("unexpected result transfer %0d", results_seen);
        bad_results++;
      end else begin
        want = due_results.pop_front();
        if (got.stationary !== want.stationary || got.status !== want.status ||
            got.avg[0] !== want.avg[0] || got.avg[1] !== want.avg[1] ||
            got.avg[2] !== want.avg[2] || got.avg[3] !== want.avg[3]) begin
          if (bad_results < 10) begin
            $display("result %0d: expected stat %0b status %0d avg %h %h %h %h",
                     results_seen, want.stationary, want.status,
                     want.avg[0], want.avg[1], want.avg[2], want.avg[3]);
            $display("result %0d:   actual stat %0b status %0d avg %h %h %h %h",
                     results_seen, got.stationary, got.status,
                     got.avg[0], got.avg[1], got.avg[2], got.avg[3]);
          end
          bad_results++;
        end
      end
      results_seen++;
      if (recv_idle == 0 && results_seen % 97 == 0) hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Watchdog: a long stretch with no transfer on either channel means the
  // block has hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan [$];
    logic [CFG_W-1:0] win_plan [6];
    logic [CFG_W-1:0] dwell_plan [6];
    int phase_end;

    for (int i = 0; i < N_CH; i++) chan_sum[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan. The first rows run with the reset values of the
    // registers, where the dwell is far too long for the flag to rise.
    plan = '{
      // A start right after reset is refused: nothing stands still yet.
      item_row(1'b1, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0, CAP_REJ_MOVING),
      // The first valid sample takes the anchor and leaves the flag low.
      item_row(1'b0, 16'h0000, 1'b0, 16'hFFFF, 1'b1, 1'b0, CAP_NONE),
      // One count backwards across the revolution seam is within the window.
      item_row(1'b0, 16'hFFFF, 1'b0, 16'h0000, 1'b1, 1'b0, CAP_NONE),
      // An invalid sample drops tracking.
      item_row(1'b0, 16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b0, CAP_NONE),
      // Zero window, shortest dwell.
      setting_row(16'h0000, 16'h0001),
      item_row(1'b0, 16'h0064, 1'b0, 16'h5A5A, 1'b1, 1'b0, CAP_NONE),
      item_row(1'b0, 16'h0064, 1'b0, 16'hA5A5, 1'b1, 1'b1, CAP_NONE),
      item_row(1'b1, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b1, CAP_STARTED),
      // A second start while the capture runs is refused as busy.
      item_row(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1, CAP_REJ_BUSY),
      item_row(1'b0, 16'h0064, 1'b0, 16'hFFFF, 1'b0, 1'b0, CAP_NONE),
      // One count of motion with a zero window aborts the capture.
      item_row(1'b0, 16'h0065, 1'b0, 16'h0000, 1'b1, 1'b0, CAP_ABORTED),
      item_row(1'b1, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0, CAP_REJ_MOVING),
      // Widest window (the top data bit is dropped) and longest dwell.
      setting_row(16'hFFFF, 16'hFFFF),
      item_row(1'b0, 16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0, CAP_NONE),
      item_row(1'b0, 16'h0000, 1'b0, 16'hFFFF, 1'b1, 1'b0, CAP_NONE),
      // Exactly half a revolution ahead and behind lies outside even the
      // widest window; one count less lies inside.
      item_row(1'b0, 16'h8000, 1'b0, 16'h1234, 1'b0, 1'b0, CAP_NONE),
      item_row(1'b0, 16'h0000, 1'b0, 16'h8765, 1'b0, 1'b0, CAP_NONE),
      item_row(1'b0, 16'h7FFF, 1'b0, 16'h0F0F, 1'b0, 1'b0, CAP_NONE),
      item_row(1'b0, 16'hFFFF, 1'b0, 16'hF0F0, 1'b0, 1'b0, CAP_NONE),
      setting_row(16'h0010, 16'h0002),
      // Re-anchor far away, then a step of exactly the window keeps still.
      item_row(1'b0, 16'h1000, 1'b0, 16'h3C3C, 1'b0, 1'b0, CAP_NONE),
      item_row(1'b0, 16'h1010, 1'b0, 16'hC3C3, 1'b0, 1'b0, CAP_NONE),
      item_row(1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, CAP_NONE),
      // An invalid sample during a capture aborts it.
      item_row(1'b0, 16'h0FF0, 1'b1, 16'h6969, 1'b0, 1'b0, CAP_NONE),
      item_row(1'b0, 16'h0FEF, 1'b0, 16'h9696, 1'b0, 1'b0, CAP_NONE)
    };
    foreach (plan[i]) begin
      if (plan[i].is_setting) apply_settings(plan[i].win_data, plan[i].dwell_data);
      else offer(plan[i].item, plan[i].typed, plan[i].typed_res);
    end

    // Register settings for the random part, extremes among them.
    win_plan[0] = CFG_W'($urandom_range(1, 40)) | {1'($urandom), 15'd0};
    dwell_plan[0] = CFG_W'($urandom_range(1, 6));
    win_plan[1] = 16'h0000;
    dwell_plan[1] = 16'h0001;
    win_plan[2] = CFG_W'($urandom_range(100, 2000));
    dwell_plan[2] = CFG_W'($urandom_range(2, 8));
    win_plan[3] = 16'hFFFF;
    dwell_plan[3] = 16'h0003;
    win_plan[4] = CFG_W'($urandom_range(0, 32767));
    dwell_plan[4] = CFG_W'($urandom_range(1, 4));
    win_plan[5] = 16'h0007;
    dwell_plan[5] = 16'h0040;

    // Two settings per stall pattern: sender idles lightly and the receiver
    // heavily, then the reverse, then neither idles (with the long hold-offs
    // of the result side).
    for (int ph = 0; ph < 6; ph++) begin
      apply_settings(win_plan[ph], dwell_plan[ph]);
      send_idle = (ph < 2) ? 22 : (ph < 4) ? 66 : 0;
      recv_idle = (ph < 2) ? 66 : (ph < 4) ? 22 : 0;
      phase_end = items_sent + 70;
      while (items_sent < phase_end) begin
        // Noise between captures: stray starts, jumps and invalid samples.
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) offer(start_item(), 1'b0, '0);
          else offer(sample_at(ANGLE_W'($urandom), $urandom_range(0, 4) == 0), 1'b0, '0);
        end
        capture_sequence();
      end
    end

    // Drain and let the pipeline settle before the verdict.
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (due_results.size() != 0) bad_results++;
    if (bad_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
